FILE: rtl/bol_pkg.sv
package bol_pkg;

    // Fixed field widths
    localparam int COMMAND_W = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Command codes; the two spare codes fall to the default arm
    typedef enum logic [COMMAND_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_DUMP       = 3'd5
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_APPENDED = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // What one cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_DUMP
    } fsm_t;

endpackage

FILE: rtl/bol_cell.sv
module bol_cell
(
    input  logic               clk,
    input  bol_pkg::cell_op_t  op,
    input  bol_pkg::value_t    load_data,
    input  bol_pkg::value_t    left_data,
    input  bol_pkg::value_t    right_data,
    output bol_pkg::value_t    data
);

    bol_pkg::value_t data_reg;
    bol_pkg::value_t data_next;

    // Pick the new entry: hold, take the load bus, or take a neighbour
    always_comb
    begin
        case (op)
            bol_pkg::CELL_LOAD:  data_next = load_data;
            bol_pkg::CELL_LEFT:  data_next = left_data;
            bol_pkg::CELL_RIGHT: data_next = right_data;
            default:             data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: rtl/bounded_ordered_list_unit.sv
// Push, insert and pop: the result is registered at the input transfer, one command per
// cycle while the output is taken; moving cells shift at once. Dump: output valid drops at
// the transfer, then one result per entry per cycle while the output is taken; the row
// rotates one place per result so the front cell carries the next entry; no input is taken
// until the dump ends. Reset clears the length, the sequencer and the output valid;
// cell contents are undefined until written and never read beyond the length.
module bounded_ordered_list_unit
#(
    parameter int CAPACITY = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bol_pkg::COMMAND_W-1:0]       command,
    input  logic signed [bol_pkg::VALUE_W-1:0]  value,
    input  logic [bol_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bol_pkg::STATUS_W-1:0]        status,
    output logic signed [bol_pkg::VALUE_W-1:0]  item_value,
    output logic [bol_pkg::COUNT_W-1:0]         entry_count,
    output logic                                last
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    // Control state
    bol_pkg::fsm_t     fsm_reg, fsm_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    // Output payload
    bol_pkg::status_t  status_reg, status_next;
    bol_pkg::value_t   item_reg, item_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;

    // Cell row
    bol_pkg::value_t   cell_data [CAPACITY];
    bol_pkg::cell_op_t cell_op [CAPACITY];
    bol_pkg::value_t   load_data;
    bol_pkg::value_t   tail_value;

    bol_pkg::command_t cmd;
    logic              out_free;
    logic              accept;
    logic              full;
    logic              is_empty;
    logic              past_end;
    logic [LEN_W-1:0]  ins_pos;
    logic              do_ins;
    logic              do_pop_front;
    logic              do_rotate;
    logic              dump_last;

    assign cmd      = bol_pkg::command_t'(command);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (fsm_reg == bol_pkg::FSM_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign full     = (len_reg == LEN_W'(CAPACITY));
    assign is_empty = (len_reg == '0);
    assign past_end = (position > bol_pkg::POS_W'(len_reg));

    // Resolve the insert position for the three push commands
    always_comb
    begin
        case (cmd)
            bol_pkg::CMD_PUSH_FRONT: ins_pos = '0;
            bol_pkg::CMD_PUSH_BACK:  ins_pos = len_reg;
            default:                 ins_pos = past_end ? len_reg : position[LEN_W-1:0];
        endcase
    end

    assign do_ins = accept && !full && (cmd == bol_pkg::CMD_PUSH_FRONT ||
                                        cmd == bol_pkg::CMD_PUSH_BACK ||
                                        cmd == bol_pkg::CMD_INSERT);
    assign do_pop_front = accept && !is_empty && (cmd == bol_pkg::CMD_POP_FRONT);
    assign do_rotate    = (fsm_reg == bol_pkg::FSM_DUMP) && out_free;
    assign dump_last    = (LEN_W'(cnt_reg) + LEN_W'(1) == len_reg);

    // Load bus: new value on insert, front entry wrapping to the tail on dump
    assign load_data = do_rotate ? cell_data[0] : value;

    // Per-cell control and the row itself
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        bol_pkg::value_t left_in;
        bol_pkg::value_t right_in;

        if (i == 0)
        begin : g_front
            assign left_in = '0;
        end
        else
        begin : g_inner_l
            assign left_in = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign right_in = '0;
        end
        else
        begin : g_inner_r
            assign right_in = cell_data[i+1];
        end

        always_comb
        begin
            cell_op[i] = bol_pkg::CELL_HOLD;
            if (do_ins)
            begin
                if (LEN_W'(i) == ins_pos)
                    cell_op[i] = bol_pkg::CELL_LOAD;
                else if (LEN_W'(i) > ins_pos && LEN_W'(i) <= len_reg)
                    cell_op[i] = bol_pkg::CELL_LEFT;
            end
            else if (do_pop_front)
            begin
                if (i < CAPACITY - 1)
                    cell_op[i] = bol_pkg::CELL_RIGHT;
            end
            else if (do_rotate)
            begin
                if (LEN_W'(i + 1) < len_reg)
                    cell_op[i] = bol_pkg::CELL_RIGHT;
                else if (LEN_W'(i + 1) == len_reg)
                    cell_op[i] = bol_pkg::CELL_LOAD;
            end
        end

        bol_cell u_cell
        (
            .clk        (clk),
            .op         (cell_op[i]),
            .load_data  (load_data),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i])
        );
    end

    // Select the tail entry for pop back
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (LEN_W'(i + 1) == len_reg)
                tail_value = tail_value | cell_data[i];
        end
    end

    // Sequencer, length and result
    always_comb
    begin
        fsm_next       = fsm_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        last_next      = last_reg;

        case (fsm_reg)
            bol_pkg::FSM_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    status_next    = bol_pkg::ST_OK;
                    item_next      = '0;
                    count_next     = len_reg;
                    last_next      = 1'b1;
                    case (cmd)
                        bol_pkg::CMD_PUSH_FRONT,
                        bol_pkg::CMD_PUSH_BACK,
                        bol_pkg::CMD_INSERT:
                        begin
                            if (full)
                                status_next = bol_pkg::ST_FULL;
                            else
                            begin
                                len_next   = len_reg + LEN_W'(1);
                                count_next = len_reg + LEN_W'(1);
                                if (cmd == bol_pkg::CMD_INSERT && past_end)
                                    status_next = bol_pkg::ST_APPENDED;
                            end
                        end
                        bol_pkg::CMD_POP_FRONT,
                        bol_pkg::CMD_POP_BACK:
                        begin
                            if (is_empty)
                                status_next = bol_pkg::ST_EMPTY;
                            else
                            begin
                                len_next   = len_reg - LEN_W'(1);
                                count_next = len_reg - LEN_W'(1);
                                item_next  = (cmd == bol_pkg::CMD_POP_FRONT) ?
                                             cell_data[0] : tail_value;
                            end
                        end
                        bol_pkg::CMD_DUMP:
                        begin
                            if (is_empty)
                                status_next = bol_pkg::ST_EMPTY;
                            else
                            begin
                                // results come from the dump sequence instead
                                out_valid_next = 1'b0;
                                cnt_next       = '0;
                                fsm_next       = bol_pkg::FSM_DUMP;
                            end
                        end
                        default:
                        begin
                            status_next = bol_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bol_pkg::FSM_DUMP:
            begin
                if (do_rotate)
                begin
                    out_valid_next = 1'b1;
                    status_next    = bol_pkg::ST_OK;
                    item_next      = cell_data[0];
                    count_next     = len_reg;
                    last_next      = dump_last;
                    cnt_next       = IDX_W'(cnt_reg + IDX_W'(1));
                    if (dump_last)
                        fsm_next = bol_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                fsm_next = bol_pkg::FSM_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= bol_pkg::FSM_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            len_reg       <= len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        item_reg   <= item_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_value  = item_reg;
    assign entry_count = bol_pkg::COUNT_W'(count_reg);
    assign last        = last_reg;

endmodule

FILE: bench/tb_bounded_ordered_list_unit.sv
`timescale 1ns / 100ps

module tb_bounded_ordered_list_unit;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_CMDS  = 360;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int REPORT_LIMIT = 100;

    // One command waiting to be driven, with its lead-in gap
    typedef struct {
        logic [bol_pkg::COMMAND_W-1:0] cmd;
        bol_pkg::value_t               val;
        logic [bol_pkg::POS_W-1:0]     pos;
        int                            gap;
        bit                            wait_empty;
    } list_cmd_t;

    // One result the list should answer with
    typedef struct {
        bol_pkg::status_t            st;
        bol_pkg::value_t             item;
        logic [bol_pkg::COUNT_W-1:0] count;
        logic                        fin;
    } list_result_t;

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [bol_pkg::COMMAND_W-1:0] command   = '0;
    bol_pkg::value_t               value     = '0;
    logic [bol_pkg::POS_W-1:0]     position  = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [bol_pkg::STATUS_W-1:0]  status;
    bol_pkg::value_t               item_value;
    logic [bol_pkg::COUNT_W-1:0]   entry_count;
    logic                          last;

    list_cmd_t       pending_cmds[$];
    list_result_t    awaited_results[$];
    bol_pkg::value_t list_model[$];

    int  expected_total = 0;
    int  received_total = 0;
    int  accepted_cmds  = 0;
    int  queued_cmds    = 0;
    int  errors         = 0;
    int  reports        = 0;
    int  cycle_count    = 0;
    int  dump_count     = 0;
    int  full_hits      = 0;
    int  empty_hits     = 0;
    int  append_hits    = 0;
    int  spare_hits     = 0;
    bit  gap_burst      = 1'b0;

    // Driver scratch
    list_cmd_t next_cmd;
    int        gap_left  = 0;
    bit        gap_armed = 1'b0;
    logic      next_valid;

    // Monitor scratch
    list_result_t want;
    int           stall_left = 0;
    bit           stall_burst = 1'b0;
    logic         next_ready;
    bit           took;

    bounded_ordered_list_unit #(
        .CAPACITY   (CAPACITY)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .item_value (item_value),
        .entry_count(entry_count),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Queue one result against the current list length
    function automatic void await_result(input bol_pkg::status_t st,
                                         input bol_pkg::value_t item,
                                         input logic fin);
        list_result_t r;
        r.st    = st;
        r.item  = item;
        r.count = bol_pkg::COUNT_W'(list_model.size());
        r.fin   = fin;
        awaited_results.push_back(r);
        expected_total++;
    endfunction

    // Apply one command to the list copy and queue what it answers
    function automatic void predict_list(input logic [bol_pkg::COMMAND_W-1:0] cmd,
                                         input bol_pkg::value_t val,
                                         input logic [bol_pkg::POS_W-1:0] pos);
        int              len;
        bol_pkg::value_t taken;
        len = list_model.size();
        case (cmd)
            bol_pkg::CMD_PUSH_FRONT, bol_pkg::CMD_PUSH_BACK, bol_pkg::CMD_INSERT:
            begin
                if (len >= CAPACITY)
                begin
                    full_hits++;
                    await_result(bol_pkg::ST_FULL, '0, 1'b1);
                end
                else if (cmd == bol_pkg::CMD_PUSH_FRONT)
                begin
                    list_model.push_front(val);
                    await_result(bol_pkg::ST_OK, '0, 1'b1);
                end
                else if (cmd == bol_pkg::CMD_PUSH_BACK)
                begin
                    list_model.push_back(val);
                    await_result(bol_pkg::ST_OK, '0, 1'b1);
                end
                else if (int'(pos) > len)
                begin
                    // past the end: append and flag it
                    append_hits++;
                    list_model.push_back(val);
                    await_result(bol_pkg::ST_APPENDED, '0, 1'b1);
                end
                else
                begin
                    list_model.insert(int'(pos), val);
                    await_result(bol_pkg::ST_OK, '0, 1'b1);
                end
            end
            bol_pkg::CMD_POP_FRONT, bol_pkg::CMD_POP_BACK:
            begin
                if (len == 0)
                begin
                    empty_hits++;
                    await_result(bol_pkg::ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    taken = (cmd == bol_pkg::CMD_POP_FRONT) ? list_model.pop_front()
                                                            : list_model.pop_back();
                    await_result(bol_pkg::ST_OK, taken, 1'b1);
                end
            end
            bol_pkg::CMD_DUMP:
            begin
                dump_count++;
                if (len == 0)
                begin
                    empty_hits++;
                    await_result(bol_pkg::ST_EMPTY, '0, 1'b1);
                end
                else
                begin
                    for (int i = 0; i < len; i++)
                        await_result(bol_pkg::ST_OK, list_model[i], (i == len - 1));
                end
            end
            default:
            begin
                // spare codes leave the list alone
                spare_hits++;
                await_result(bol_pkg::ST_OK, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic bol_pkg::value_t pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return bol_pkg::value_t'($urandom);
        endcase
    endfunction

    function automatic logic [bol_pkg::POS_W-1:0] pick_position();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return bol_pkg::POS_W'($urandom_range(0, CAPACITY));
            2:       return bol_pkg::POS_W'($urandom_range(0, 127));
            default: return bol_pkg::POS_W'($urandom_range(0, 20));
        endcase
    endfunction

    task automatic queue_cmd(input logic [bol_pkg::COMMAND_W-1:0] cmd,
                             input bol_pkg::value_t val,
                             input logic [bol_pkg::POS_W-1:0] pos, input bit wait_empty);
        list_cmd_t c;
        c.cmd        = cmd;
        c.val        = val;
        c.pos        = pos;
        c.gap        = gap_burst ? 0 : $urandom_range(0, 15);
        c.wait_empty = wait_empty;
        pending_cmds.push_back(c);
    endtask

    // Draw a command according to the phase mix
    function automatic logic [bol_pkg::COMMAND_W-1:0] pick_command(input int mix);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        case (mix)
            0:       begin push_lim = 70; pop_lim = 88; end
            1:       begin push_lim = 20; pop_lim = 85; end
            2:       begin push_lim = 45; pop_lim = 85; end
            default: begin push_lim = 92; pop_lim = 92; end
        endcase
        if (r < push_lim)
            return bol_pkg::COMMAND_W'($urandom_range(bol_pkg::CMD_PUSH_FRONT,
                                                      bol_pkg::CMD_INSERT));
        else if (r < pop_lim)
            return ($urandom_range(0, 1) != 0) ? bol_pkg::CMD_POP_FRONT
                                               : bol_pkg::CMD_POP_BACK;
        else if (r < 97 || mix == 3)
            return bol_pkg::CMD_DUMP;
        else
            return bol_pkg::COMMAND_W'($urandom_range(6, 7));
    endfunction

    // Stimulus: directed corners, then random phases; hold reset and wrap up
    initial
    begin
        int mix;
        int phase_left;
        int n;
        logic [bol_pkg::COMMAND_W-1:0] c;

        // Empty-list corners, spare codes, every insert flavour
        queue_cmd(bol_pkg::CMD_DUMP,       bol_pkg::value_t'($urandom), 7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_POP_FRONT,  bol_pkg::value_t'($urandom), 7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_POP_BACK,   bol_pkg::value_t'($urandom), 7'd0,   1'b0);
        queue_cmd(3'd6,                    32'sh7fff_ffff,              7'd127, 1'b0);
        queue_cmd(bol_pkg::CMD_INSERT,     32'sh8000_0000,              7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_PUSH_FRONT, 32'sh7fff_ffff,              7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_PUSH_BACK,  '0,                          7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_INSERT,     -32'sd1,                     7'd3,   1'b0);
        queue_cmd(bol_pkg::CMD_INSERT,     32'sh5555_aaaa,              7'd127, 1'b0);
        queue_cmd(bol_pkg::CMD_INSERT,     32'sh2aaa_5555,              7'd1,   1'b0);
        queue_cmd(bol_pkg::CMD_INSERT,     32'sh1234_5678,              7'd64,  1'b0);
        queue_cmd(bol_pkg::CMD_DUMP,       '0,                          7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_POP_FRONT,  '0,                          7'd0,   1'b0);
        queue_cmd(bol_pkg::CMD_POP_BACK,   '0,                          7'd0,   1'b0);
        queue_cmd(3'd7,                    -32'sd1,                     7'd127, 1'b0);
        queue_cmd(bol_pkg::CMD_DUMP,       '0,                          7'd0,   1'b0);

        // Random phases; the first floods the list to full after a drain pause
        mix        = 3;
        phase_left = 30;
        for (n = 0; n < RANDOM_CMDS; n++)
        begin
            if (phase_left == 0)
            begin
                mix        = $urandom_range(0, 3);
                phase_left = $urandom_range(15, 40);
                gap_burst  = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            c = pick_command(mix);
            queue_cmd(c, pick_value(), pick_position(),
                      (n == 0) || ($urandom_range(0, 49) == 0));
        end
        queued_cmds = pending_cmds.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command to transfer and every answer to arrive
        @(posedge clk);
        while (accepted_cmds != queued_cmds || expected_total != received_total)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, awaited_results.size());
            errors++;
        end
        $display("Ran %0d commands, %0d results checked, %0d dumps, %0d spare codes.",
                 accepted_cmds, received_total, dump_count, spare_hits);
        $display("Hit full %0d times, empty %0d times, append past end %0d times.",
                 full_hits, empty_hits, append_hits);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Driver: predict each transfer, then present the next command after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            command   <= '0;
            value     <= '0;
            position  <= '0;
            gap_left  = 0;
            gap_armed = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_list(command, value, position);
                accepted_cmds++;
            end
            if (!in_valid || in_ready)
            begin
                next_valid = 1'b0;
                if (pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds[0];
                    if (!gap_armed)
                    begin
                        gap_left  = next_cmd.gap;
                        gap_armed = 1'b1;
                    end
                    // hold off until the list has answered everything
                    if (!(next_cmd.wait_empty && expected_total != received_total))
                    begin
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            void'(pending_cmds.pop_front());
                            command    <= next_cmd.cmd;
                            value      <= next_cmd.val;
                            position   <= next_cmd.pos;
                            next_valid = 1'b1;
                            gap_armed  = 1'b0;
                        end
                    end
                end
                in_valid <= next_valid;
            end
        end
    end

    // Monitor: check each result transfer, then stall before taking the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_left  = 0;
        end
        else
        begin
            took       = out_valid && out_ready;
            next_ready = out_ready;
            if (took)
            begin
                received_total <= received_total + 1;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (reports < REPORT_LIMIT)
                        $display("%0t: unexpected status %0d value %0d count %0d last %0b",
                                 $time, status, item_value, entry_count, last);
                    reports++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.st || item_value !== want.item ||
                        entry_count !== want.count || last !== want.fin)
                    begin
                        errors++;
                        if (reports < REPORT_LIMIT)
                        begin
                            $display("%0t: expected status %0d value %0d count %0d last %0b",
                                     $time, want.st, want.item, want.count, want.fin);
                            $display("%0t: actual   status %0d value %0d count %0d last %0b",
                                     $time, status, item_value, entry_count, last);
                        end
                        reports++;
                    end
                end
                // switch between steady taking and random stalls now and then
                if ($urandom_range(0, 29) == 0)
                    stall_burst = ~stall_burst;
                stall_left = stall_burst ? 0 : $urandom_range(0, 15);
            end
            if (took || !out_ready)
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    next_ready = 1'b0;
                end
                else
                    next_ready = 1'b1;
            end
            out_ready <= next_ready;
        end
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
